// ===== rtl/bsm3_pkg.sv =====
// Shared constants for the clipped 3x3 box smoothing block.
// Holds data widths, sizing and the reciprocal table used to divide sums by counts.
// No dependencies.
package bsm3_pkg;

    localparam int MAX_SIZE  = 64;
    localparam int DATA_W    = 16;
    localparam int POS_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int COL_W     = DATA_W + 2;
    localparam int SUM_W     = DATA_W + 4;
    localparam int MAG_W     = DATA_W + 3;
    localparam int DIV_SHIFT = MAG_W + 4;
    localparam int K_W       = DIV_SHIFT + 1;
    localparam int PROD_W    = MAG_W + K_W;
    localparam int QUOT_W    = DATA_W + 1;
    localparam int CNT_W     = 4;

    // Rounded-up reciprocals scaled by 2**DIV_SHIFT. The rounding error times the largest
    // magnitude stays below 2**DIV_SHIFT, so the shifted product is the exact floor.
    localparam logic [K_W-1:0] K_DIV1 = K_W'(64'd1 << DIV_SHIFT);
    localparam logic [K_W-1:0] K_DIV2 = K_W'(64'd1 << (DIV_SHIFT - 1));
    localparam logic [K_W-1:0] K_DIV3 = K_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);
    localparam logic [K_W-1:0] K_DIV4 = K_W'(64'd1 << (DIV_SHIFT - 2));
    localparam logic [K_W-1:0] K_DIV6 = K_W'(((64'd1 << DIV_SHIFT) + 64'd5) / 64'd6);
    localparam logic [K_W-1:0] K_DIV9 = K_W'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);

    // Reciprocal for a neighborhood count. Counts outside the clipped set never occur.
    function automatic logic [K_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [K_W-1:0] k;
        case (cnt)
            4'd1:    k = K_DIV1;
            4'd2:    k = K_DIV2;
            4'd3:    k = K_DIV3;
            4'd4:    k = K_DIV4;
            4'd6:    k = K_DIV6;
            4'd9:    k = K_DIV9;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/bsm3_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Read data updates only when the read enable is high. No dependencies.
module bsm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/box_smoothing_3x3_clipped_top.sv =====
// Top level of the clipped 3x3 box smoothing block.
// Depends on bsm3_pkg (constants, reciprocal table) and bsm3_ram (column history memory).
//
// Usage: a square signed matrix enters as a row-major stream of sample_value requests on
// the in_valid/in_stall channel. Each result request on out_valid/out_stall carries the
// mean of the 3x3 neighborhood of one position, clipped to the matrix edges, truncated
// toward zero, with its row, column and an is_last flag on the final element.
// A result leaves as soon as its neighborhood has arrived: one row and one column behind
// the input, with extra results at the right column and along the last row.
// The side length is written through cfg_valid/cfg_ready/matrix_size; the user must do
// so only while the block is idle, which the block does not enforce. A write restarts the
// matrix. Zero acts as one, values above 64 act as 64. Throughput: one input request per
// cycle while in_stall is low. Requests in the right column or the last row give several
// results, which stall the input until the single divide path has taken them all. The
// result register, the divide stages and the burst register let new input be taken while
// a finished result waits on out_stall. A request passes the stage 1 register, the burst
// register, the divide stages and the result register to out_valid. A memory of 64 words
// holds the two previous rows of each column; each request reads its column when accepted
// and writes it back on leaving the first stage, which waits on a busy burst register.
// Reset clears the position counters and all valid flags and sets the side length to 8.
// When the receiver stalls, results back up through the divide stages into the burst
// register, after which in_stall rises.
module box_smoothing_3x3_clipped_top (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [bsm3_pkg::SIZE_W-1:0]                matrix_size,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic signed [bsm3_pkg::DATA_W-1:0]         sample_value,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [bsm3_pkg::DATA_W-1:0]         mean_value,
    output logic [bsm3_pkg::POS_W-1:0]                 out_row,
    output logic [bsm3_pkg::POS_W-1:0]                 out_col,
    output logic                                       is_last
);

    typedef struct packed {
        logic signed [bsm3_pkg::SUM_W-1:0] sum;
        logic [bsm3_pkg::CNT_W-1:0]        cnt;
        logic [bsm3_pkg::POS_W-1:0]        row;
        logic [bsm3_pkg::POS_W-1:0]        col;
        logic                              last;
    } result_t;

    localparam int RAM_W = 2 * bsm3_pkg::DATA_W;

    // Configuration and position counters.
    logic [bsm3_pkg::POS_W-1:0] last_idx_reg, last_idx_next;
    logic [bsm3_pkg::POS_W-1:0] row_reg, row_next;
    logic [bsm3_pkg::POS_W-1:0] col_reg, col_next;
    logic                       cfg_write;
    logic                       accept;

    // Stage 1: the request whose column history is on the memory output.
    logic                              p1_valid_reg, p1_valid_next;
    logic signed [bsm3_pkg::DATA_W-1:0] p1_sample_reg;
    logic [bsm3_pkg::POS_W-1:0]        p1_row_reg;
    logic [bsm3_pkg::POS_W-1:0]        p1_col_reg;
    logic                              p1_move;

    logic [RAM_W-1:0]                  ram_rdata;
    logic [RAM_W-1:0]                  ram_wdata;
    logic signed [bsm3_pkg::DATA_W-1:0] prev1;
    logic signed [bsm3_pkg::DATA_W-1:0] prev2;

    // Vertical sums of the last two columns, for the full and the last-row window.
    logic signed [bsm3_pkg::COL_W-1:0] vs1_reg, vs2_reg, vp1_reg, vp2_reg;
    logic signed [bsm3_pkg::COL_W-1:0] v_sum, vp_sum;

    logic    r_ge1, r_ge2, c_ge1, c_ge2, r_last, c_last;
    logic [1:0] rf_full, rf_last, cf_mid, cf_end;
    result_t new_entry [4];
    logic [3:0] new_mask;

    // Burst register: up to four results of one request, drained one per cycle on m_ready.
    result_t    burst_reg [4];
    logic [3:0] mask_reg, mask_next;
    logic [3:0] mask_after_pop;
    logic [1:0] pop_idx;
    logic       pop_en;
    result_t    pop_entry;
    logic signed [bsm3_pkg::SUM_W-1:0] pop_neg_sum;

    // Divide stages and result register.
    logic                            m_valid_reg, m_valid_next;
    logic [bsm3_pkg::MAG_W-1:0]      m_mag_reg;
    logic [bsm3_pkg::K_W-1:0]        m_k_reg;
    logic                            m_neg_reg;
    logic [bsm3_pkg::POS_W-1:0]      m_row_reg, m_col_reg;
    logic                            m_last_reg;
    logic                            m_ready, m_adv;
    logic [bsm3_pkg::PROD_W-1:0]     m_prod;

    logic                            p_valid_reg, p_valid_next;
    logic [bsm3_pkg::QUOT_W-1:0]     p_quot_reg;
    logic                            p_neg_reg;
    logic [bsm3_pkg::POS_W-1:0]      p_row_reg, p_col_reg;
    logic                            p_last_reg;
    logic                            p_ready, p_adv;
    logic [bsm3_pkg::QUOT_W-1:0]     p_signed_quot;

    logic                              out_valid_reg, out_valid_next;
    logic signed [bsm3_pkg::DATA_W-1:0] mean_reg;
    logic [bsm3_pkg::POS_W-1:0]        row_out_reg, col_out_reg;
    logic                              last_out_reg;
    logic                              o_ready;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = p1_valid_reg && !p1_move;
    assign accept    = in_valid && !in_stall;

    // Side length clamp, kept as the index of the last row and column.
    always_comb
    begin
        last_idx_next = last_idx_reg;
        if (cfg_write)
        begin
            if (matrix_size == '0)
            begin
                last_idx_next = '0;
            end
            else if (matrix_size > bsm3_pkg::SIZE_W'(bsm3_pkg::MAX_SIZE))
            begin
                last_idx_next = bsm3_pkg::POS_W'(bsm3_pkg::MAX_SIZE - 1);
            end
            else
            begin
                last_idx_next = bsm3_pkg::POS_W'(matrix_size - 1'b1);
            end
        end
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_idx_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_idx_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Each memory word holds the column's values from two rows back and one row back.
    bsm3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (bsm3_pkg::MAX_SIZE)
    ) u_col_ram (
        .clk   (clk),
        .we    (p1_move),
        .waddr (p1_col_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign prev2     = ram_rdata[RAM_W-1:bsm3_pkg::DATA_W];
    assign prev1     = ram_rdata[bsm3_pkg::DATA_W-1:0];
    assign ram_wdata = {prev1, p1_sample_reg};

    // Stage 1: vertical sums and the set of results this request completes.
    always_comb
    begin
        r_ge1  = p1_row_reg != '0;
        r_ge2  = p1_row_reg > bsm3_pkg::POS_W'(1);
        c_ge1  = p1_col_reg != '0;
        c_ge2  = p1_col_reg > bsm3_pkg::POS_W'(1);
        r_last = p1_row_reg == last_idx_reg;
        c_last = p1_col_reg == last_idx_reg;

        v_sum  = bsm3_pkg::COL_W'(p1_sample_reg) + bsm3_pkg::COL_W'(prev1)
               + (r_ge2 ? bsm3_pkg::COL_W'(prev2) : '0);
        vp_sum = bsm3_pkg::COL_W'(p1_sample_reg) + (r_ge1 ? bsm3_pkg::COL_W'(prev1) : '0);

        rf_full = r_ge2 ? 2'd3 : 2'd2;
        rf_last = r_ge1 ? 2'd2 : 2'd1;
        cf_mid  = c_ge2 ? 2'd3 : 2'd2;
        cf_end  = c_ge1 ? 2'd2 : 2'd1;

        // Previous row, previous column.
        new_entry[0].sum  = bsm3_pkg::SUM_W'(v_sum) + bsm3_pkg::SUM_W'(vs1_reg)
                          + (c_ge2 ? bsm3_pkg::SUM_W'(vs2_reg) : '0);
        new_entry[0].cnt  = bsm3_pkg::CNT_W'(rf_full) * bsm3_pkg::CNT_W'(cf_mid);
        new_entry[0].row  = p1_row_reg - 1'b1;
        new_entry[0].col  = p1_col_reg - 1'b1;
        new_entry[0].last = 1'b0;

        // Previous row, this column, at the right edge.
        new_entry[1].sum  = bsm3_pkg::SUM_W'(v_sum)
                          + (c_ge1 ? bsm3_pkg::SUM_W'(vs1_reg) : '0);
        new_entry[1].cnt  = bsm3_pkg::CNT_W'(rf_full) * bsm3_pkg::CNT_W'(cf_end);
        new_entry[1].row  = p1_row_reg - 1'b1;
        new_entry[1].col  = p1_col_reg;
        new_entry[1].last = 1'b0;

        // Last row, previous column.
        new_entry[2].sum  = bsm3_pkg::SUM_W'(vp_sum) + bsm3_pkg::SUM_W'(vp1_reg)
                          + (c_ge2 ? bsm3_pkg::SUM_W'(vp2_reg) : '0);
        new_entry[2].cnt  = bsm3_pkg::CNT_W'(rf_last) * bsm3_pkg::CNT_W'(cf_mid);
        new_entry[2].row  = p1_row_reg;
        new_entry[2].col  = p1_col_reg - 1'b1;
        new_entry[2].last = 1'b0;

        // Last row, last column.
        new_entry[3].sum  = bsm3_pkg::SUM_W'(vp_sum)
                          + (c_ge1 ? bsm3_pkg::SUM_W'(vp1_reg) : '0);
        new_entry[3].cnt  = bsm3_pkg::CNT_W'(rf_last) * bsm3_pkg::CNT_W'(cf_end);
        new_entry[3].row  = p1_row_reg;
        new_entry[3].col  = p1_col_reg;
        new_entry[3].last = 1'b1;

        new_mask = {r_last && c_last, r_last && c_ge1, r_ge1 && c_last, r_ge1 && c_ge1};
    end

    // Burst drain: lowest pending result first keeps row-major order.
    always_comb
    begin
        if (mask_reg[0])
        begin
            pop_idx = 2'd0;
        end
        else if (mask_reg[1])
        begin
            pop_idx = 2'd1;
        end
        else if (mask_reg[2])
        begin
            pop_idx = 2'd2;
        end
        else
        begin
            pop_idx = 2'd3;
        end
        pop_en         = (mask_reg != '0) && m_ready;
        pop_entry      = burst_reg[pop_idx];
        pop_neg_sum    = -pop_entry.sum;
        mask_after_pop = mask_reg & ~(pop_en ? (4'b0001 << pop_idx) : 4'b0000);
        p1_move        = p1_valid_reg && ((new_mask == '0) || (mask_after_pop == '0));
        mask_next      = (p1_move && (new_mask != '0)) ? new_mask : mask_after_pop;
        p1_valid_next  = accept || (p1_valid_reg && !p1_move);
    end

    // Divide pipeline handshakes.
    assign o_ready = !out_valid_reg || !out_stall;
    assign p_ready = !p_valid_reg || o_ready;
    assign p_adv   = p_valid_reg && o_ready;
    assign m_ready = !m_valid_reg || p_ready;
    assign m_adv   = m_valid_reg && p_ready;

    assign m_valid_next   = pop_en || (m_valid_reg && !m_adv);
    assign p_valid_next   = m_adv || (p_valid_reg && !p_adv);
    assign out_valid_next = p_adv || (out_valid_reg && out_stall);

    assign m_prod        = bsm3_pkg::PROD_W'(m_mag_reg) * bsm3_pkg::PROD_W'(m_k_reg);
    assign p_signed_quot = p_neg_reg ? -p_quot_reg : p_quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_idx_reg  <= bsm3_pkg::POS_W'(7);
            row_reg       <= '0;
            col_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            mask_reg      <= '0;
            m_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_idx_reg  <= last_idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            p1_valid_reg  <= p1_valid_next;
            mask_reg      <= mask_next;
            m_valid_reg   <= m_valid_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_sample_reg <= sample_value;
            p1_row_reg    <= row_reg;
            p1_col_reg    <= col_reg;
        end
        if (p1_move)
        begin
            vs1_reg <= v_sum;
            vs2_reg <= vs1_reg;
            vp1_reg <= vp_sum;
            vp2_reg <= vp1_reg;
        end
        if (p1_move && (new_mask != '0))
        begin
            for (int i = 0; i < 4; i++)
            begin
                burst_reg[i] <= new_entry[i];
            end
        end
        if (pop_en)
        begin
            m_neg_reg  <= pop_entry.sum[bsm3_pkg::SUM_W-1];
            m_mag_reg  <= pop_entry.sum[bsm3_pkg::SUM_W-1] ?
                          pop_neg_sum[bsm3_pkg::MAG_W-1:0] :
                          pop_entry.sum[bsm3_pkg::MAG_W-1:0];
            m_k_reg    <= bsm3_pkg::recip(pop_entry.cnt);
            m_row_reg  <= pop_entry.row;
            m_col_reg  <= pop_entry.col;
            m_last_reg <= pop_entry.last;
        end
        if (m_adv)
        begin
            p_quot_reg <= m_prod[bsm3_pkg::DIV_SHIFT +: bsm3_pkg::QUOT_W];
            p_neg_reg  <= m_neg_reg;
            p_row_reg  <= m_row_reg;
            p_col_reg  <= m_col_reg;
            p_last_reg <= m_last_reg;
        end
        if (p_adv)
        begin
            mean_reg     <= p_signed_quot[bsm3_pkg::DATA_W-1:0];
            row_out_reg  <= p_row_reg;
            col_out_reg  <= p_col_reg;
            last_out_reg <= p_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mean_value = mean_reg;
    assign out_row    = row_out_reg;
    assign out_col    = col_out_reg;
    assign is_last    = last_out_reg;

endmodule
